/* hw/rtl/homogeneous_point_vector_transform_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the homogeneous point/vector transform
// Immediate-consequence and next-cycle property wrappers.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_VECTOR_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_VECTOR_TRANSFORM_MACROS_SVH

// same-cycle implication
`define HPVT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hpvt assertion failed");

// next-cycle implication
`define HPVT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hpvt assertion failed");

`endif

/* hw/rtl/hpvt_pkg.sv */
// ----------------------------------------------------------------------------
// hpvt_pkg
// Types, constants and helpers shared by the transform block.
// ----------------------------------------------------------------------------
package hpvt_pkg;

   localparam int NUM_REGS   = 8;
   localparam int ADDR_W     = 6;
   localparam int RW         = 50;   // rounded row sum width (signed)
   localparam int DIV_STEPS  = 32;   // quotient bits, one per stage
   localparam int DIV_STAGES = DIV_STEPS + 1;
   localparam int NST        = DIV_STAGES + 3;  // mult, sum, divide, output

   localparam logic signed [RW-1:0] ONE_Q16 = RW'(65536);
   localparam logic signed [RW-1:0] MAX32 = $signed({{(RW-32){1'b0}}, 32'h7fffffff});
   localparam logic signed [RW-1:0] MIN32 = $signed({{(RW-32){1'b1}}, 32'h80000000});

   localparam logic [NUM_REGS-1:0][63:0] REG_RESET = '{
      64'h0000000000010000, 64'h0000000000000000,
      64'h0001000000000000, 64'h0000000000000000,
      64'h0000000000000000, 64'h0000000000010000,
      64'h0000000000000000, 64'h0001000000000000
   };

   typedef struct packed {
      logic               mode;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               w_zero;
      logic               clipped;
   } rsp_type;

   typedef logic [3:0][3:0][31:0] coef_mat_type;

   typedef struct packed {
      logic        clip;
      logic [31:0] val;
   } sat_type;

   typedef struct packed {
      logic        wz;
      logic        clip;
      logic [31:0] val;
   } div_res_type;

   function automatic sat_type sat32(input logic signed [RW-1:0] v);
      sat_type s;
      if (v > MAX32) begin
         s.clip = 1'b1;
         s.val  = 32'h7fffffff;
      end else if (v < MIN32) begin
         s.clip = 1'b1;
         s.val  = 32'h80000000;
      end else begin
         s.clip = 1'b0;
         s.val  = v[31:0];
      end
      return s;
   endfunction

endpackage

/* hw/rtl/hpvt_csr.sv */
// ----------------------------------------------------------------------------
// hpvt_csr
// APB register file holding the 4x4 Q16.16 matrix.
// ----------------------------------------------------------------------------
module hpvt_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [hpvt_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [63:0]                 csr_pwdata,
   output logic [63:0]                 csr_prdata,
   output hpvt_pkg::coef_mat_type      coef
);
   import hpvt_pkg::*;

   logic [63:0] regs_ff [NUM_REGS];
   logic [2:0]  idx;

   assign idx = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= REG_RESET[i];
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         regs_ff[idx] <= csr_pwdata;
      end
   end

   assign csr_prdata = regs_ff[idx];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         coef[r][0] = regs_ff[2*r][63:32];
         coef[r][1] = regs_ff[2*r][31:0];
         coef[r][2] = regs_ff[2*r+1][63:32];
         coef[r][3] = regs_ff[2*r+1][31:0];
      end
   end

endmodule

/* hw/rtl/hpvt_dot_lane.sv */
// ----------------------------------------------------------------------------
// hpvt_dot_lane
// One matrix row: three products, then exact sum and round to Q16.16.
// ----------------------------------------------------------------------------
module hpvt_dot_lane (
   input  logic                          clock,
   input  logic [1:0]                    en,
   input  logic                          affine,
   input  logic signed [31:0]            vx,
   input  logic signed [31:0]            vy,
   input  logic signed [31:0]            vz,
   input  logic [3:0][31:0]              row,
   output logic signed [hpvt_pkg::RW-1:0] sum
);
   import hpvt_pkg::*;

   logic signed [63:0] p0_ff, p1_ff, p2_ff;
   logic signed [31:0] t_ff;
   logic signed [65:0] tot;
   logic signed [RW-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p0_ff <= $signed(row[0]) * vx;
         p1_ff <= $signed(row[1]) * vy;
         p2_ff <= $signed(row[2]) * vz;
         t_ff  <= affine ? $signed(row[3]) : 32'sd0;
      end
      if (en[1]) sum_ff <= tot[65:16];
   end

   // round half toward plus infinity
   assign tot = 66'(p0_ff) + 66'(p1_ff) + 66'(p2_ff) + (66'(t_ff) <<< 16) + 66'sd32768;
   assign sum = sum_ff;

endmodule

/* hw/rtl/hpvt_div_lane.sv */
// ----------------------------------------------------------------------------
// hpvt_div_lane
// Pipelined restoring divide of one coordinate by w, one quotient bit a stage,
// with the no-divide and zero-w cases carried alongside.
// ----------------------------------------------------------------------------
module hpvt_div_lane (
   input  logic                              clock,
   input  logic [hpvt_pkg::DIV_STAGES-1:0]   en,
   input  logic                              vec,
   input  logic signed [hpvt_pkg::RW-1:0]    num,
   input  logic signed [hpvt_pkg::RW-1:0]    den,
   output hpvt_pkg::div_res_type             res
);
   import hpvt_pkg::*;

   logic [RW-1:0]        rem_ff [DIV_STAGES];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STAGES];
   logic [31:0]          nb_ff  [DIV_STAGES];
   logic [RW-1:0]        aw_ff  [DIV_STAGES];
   logic                 neg_ff [DIV_STAGES];
   logic                 ovf_ff [DIV_STAGES];
   logic                 byp_ff [DIV_STAGES];
   logic                 wz_ff  [DIV_STAGES];
   sat_type              bres_ff[DIV_STAGES];

   logic [RW-1:0] ax, aw;
   logic          is_one, is_zero, ovf;
   sat_type       bres;
   logic [RW:0]   t_w   [DIV_STEPS];
   logic          ge_w  [DIV_STEPS];
   logic [RW-1:0] rem_w [DIV_STEPS];
   logic [32:0]   mag;
   logic signed [RW-1:0] mext, sval;
   sat_type       qres;

   // setup: magnitudes, overflow test, special cases
   always_comb begin
      ax      = num[RW-1] ? RW'(-num) : RW'(num);
      aw      = den[RW-1] ? RW'(-den) : RW'(den);
      is_one  = (den == ONE_Q16);
      is_zero = (den == '0);
      ovf     = {15'd0, ax} >= {aw, 15'd0};
      if (vec || is_one) begin
         bres = sat32(num);
      end else begin
         bres.clip = 1'b1;
         bres.val  = num[RW-1] ? 32'h80000000 : 32'h7fffffff;
      end
   end

   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         t_w[k]   = {rem_ff[k], nb_ff[k][31]};
         ge_w[k]  = t_w[k] >= {1'b0, aw_ff[k]};
         rem_w[k] = ge_w[k] ? RW'(t_w[k] - {1'b0, aw_ff[k]}) : t_w[k][RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0]  <= RW'(ax >> 15);
         nb_ff[0]   <= {ax[14:0], 17'd0};
         q_ff[0]    <= '0;
         aw_ff[0]   <= aw;
         neg_ff[0]  <= num[RW-1] ^ den[RW-1];
         ovf_ff[0]  <= ovf;
         byp_ff[0]  <= vec || is_one || is_zero;
         wz_ff[0]   <= !vec && is_zero;
         bres_ff[0] <= bres;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_w[k-1];
            nb_ff[k]   <= {nb_ff[k-1][30:0], 1'b0};
            q_ff[k]    <= {q_ff[k-1][DIV_STEPS-2:0], ge_w[k-1]};
            aw_ff[k]   <= aw_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            byp_ff[k]  <= byp_ff[k-1];
            wz_ff[k]   <= wz_ff[k-1];
            bres_ff[k] <= bres_ff[k-1];
         end
      end
   end

   // round half away from zero, apply sign, saturate
   always_comb begin
      mag  = ovf_ff[DIV_STAGES-1] ? 33'h100000000
           : 33'(({1'b0, q_ff[DIV_STAGES-1]} + 33'd1) >> 1);
      mext = $signed(RW'(mag));
      sval = neg_ff[DIV_STAGES-1] ? -mext : mext;
      qres = sat32(sval);
      res.wz = wz_ff[DIV_STAGES-1];
      if (byp_ff[DIV_STAGES-1]) begin
         res.clip = bres_ff[DIV_STAGES-1].clip;
         res.val  = bres_ff[DIV_STAGES-1].val;
      end else begin
         res.clip = qres.clip;
         res.val  = qres.val;
      end
   end

endmodule

/* hw/rtl/homogeneous_point_vector_transform.sv */
// ----------------------------------------------------------------------------
// homogeneous_point_vector_transform
// 4x4 Q16.16 matrix applied to one 3D point or direction per request.
// ----------------------------------------------------------------------------
// One request is accepted per clock while the pipeline is not stalled, and each
// gives one response after a product stage, a rounded row sum stage, the
// divide by w (setup plus one quotient bit per stage) and one output register.
// The latency is the same in vector mode and when no divide is needed, so
// responses leave in request order. Each stage moves whenever the stage after
// it is empty or moving, so a stalled response only blocks once every stage is
// full. The matrix is written through the APB port at byte address 8*i.
// ----------------------------------------------------------------------------
`include "homogeneous_point_vector_transform_macros.svh"

module homogeneous_point_vector_transform (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  hpvt_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output hpvt_pkg::rsp_type           rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [hpvt_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [63:0]                 csr_pwdata,
   output logic [63:0]                 csr_prdata,
   output logic                        csr_pready
);
   import hpvt_pkg::*;

   // stage map: 0 products, 1 row sums, 2..NST-2 divide, NST-1 output
   localparam int OUT_ST = NST - 1;

   logic [NST-1:0] vld_ff, vld_in;
   logic [NST:0]   en;
   coef_mat_type   coef;
   logic           mode0_ff, mode1_ff;
   logic signed [RW-1:0] sums [4];
   div_res_type    dres [3];
   rsp_type        rsp_ff;

   assign csr_pready = 1'b1;

   hpvt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .coef        (coef)
   );

   // stall chain: a stage may load when it is empty or its content moves on
   always_comb begin
      en[NST] = rsp_ready;
      for (int i = NST - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      for (int i = 0; i < NST; i++) begin
         if (en[i]) begin
            vld_in[i] = (i == 0) ? req_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // mode follows the item to the divide setup
   always_ff @(posedge clock) begin
      if (en[0]) mode0_ff <= req_data.mode;
      if (en[1]) mode1_ff <= mode0_ff;
   end

   // four row lanes; translation only in point mode, w row always affine
   for (genvar r = 0; r < 4; r++) begin : g_row
      hpvt_dot_lane u_dot (
         .clock  (clock),
         .en     (en[1:0]),
         .affine ((r == 3) ? 1'b1 : !req_data.mode),
         .vx     (req_data.in_x),
         .vy     (req_data.in_y),
         .vz     (req_data.in_z),
         .row    (coef[r]),
         .sum    (sums[r])
      );
   end

   // three divide lanes share w from the projective row
   for (genvar k = 0; k < 3; k++) begin : g_div
      hpvt_div_lane u_div (
         .clock (clock),
         .en    (en[OUT_ST-1:2]),
         .vec   (mode1_ff),
         .num   (sums[k]),
         .den   (sums[3]),
         .res   (dres[k])
      );
   end

   // merge: pack coordinates, any saturation sets clipped
   always_ff @(posedge clock) begin
      if (en[OUT_ST]) begin
         rsp_ff.out_x   <= dres[0].val;
         rsp_ff.out_y   <= dres[1].val;
         rsp_ff.out_z   <= dres[2].val;
         rsp_ff.w_zero  <= dres[0].wz;
         rsp_ff.clipped <= dres[0].clip | dres[1].clip | dres[2].clip;
      end
   end

   assign rsp_valid = vld_ff[OUT_ST];
   assign rsp_data  = rsp_ff;

   `HPVT_ASSERT_NOW(a_wz_clips, clock, reset, rsp_valid && rsp_data.w_zero, rsp_data.clipped)
   `HPVT_ASSERT_NOW(a_stall_full, clock, reset, !req_ready, &vld_ff)
   `HPVT_ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && req_ready, vld_ff[0])

endmodule

/* bench/hpvt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpvt_checker
// Watches the request, response and APB channels, predicts each response
// from a shadow copy of the matrix and compares field by field.
// ----------------------------------------------------------------------------
module hpvt_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  hpvt_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  hpvt_pkg::rsp_type           rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic                        csr_pready,
   input  logic [hpvt_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [63:0]                 csr_pwdata,
   output int                          errors,
   output int                          pending
);
   import hpvt_pkg::*;

   typedef logic signed [127:0] wide_type;

   localparam logic [63:0] MTX_RESET [NUM_REGS] = '{
      64'h0001000000000000, 64'h0000000000000000,
      64'h0000000000010000, 64'h0000000000000000,
      64'h0000000000000000, 64'h0001000000000000,
      64'h0000000000000000, 64'h0000000000010000
   };

   logic [63:0] shadow_mtx [NUM_REGS];
   rsp_type     expected_rsp [$];

   assign pending = expected_rsp.size();

   function automatic wide_type coef(input int row, input int col);
      logic [63:0] r;
      r = shadow_mtx[row * 2 + col / 2];
      return (col % 2) ? wide_type'($signed(r[31:0])) : wide_type'($signed(r[63:32]));
   endfunction

   // exact Q32.32 row sum, rounded to Q16.16 with ties toward +inf
   function automatic wide_type row_sum(input int row, input wide_type v [3],
                                        input logic affine);
      wide_type s;
      s = 0;
      for (int c = 0; c < 3; c++) s += coef(row, c) * v[c];
      if (affine) s += coef(row, 3) <<< 16;
      return (s + 32768) >>> 16;
   endfunction

   function automatic logic [31:0] clamp(input wide_type v, inout logic clip);
      if (v > 64'sh7fffffff) begin
         clip = 1'b1;
         return 32'h7fffffff;
      end
      if (v < -64'sh80000000) begin
         clip = 1'b1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // Q16.16 quotient, nearest with ties away from zero
   function automatic logic [31:0] quotient(input wide_type x, input wide_type w,
                                            inout logic clip);
      wide_type ax, aw, q, mag;
      logic     neg;
      neg = (x < 0) != (w < 0);
      ax  = (x < 0) ? -x : x;
      aw  = (w < 0) ? -w : w;
      // integer part of 2^15 or more always saturates
      if (ax >= (aw <<< 15)) begin
         mag = wide_type'(1) <<< 32;
      end else begin
         q   = (ax <<< 17) / aw;
         mag = (q + 1) >>> 1;
      end
      return clamp(neg ? -mag : mag, clip);
   endfunction

   function automatic rsp_type transform(input req_type r);
      wide_type v [3];
      wide_type num [3];
      wide_type w;
      logic     clip;
      logic [31:0] res [3];
      rsp_type  o;
      clip = 1'b0;
      v[0] = r.in_x;
      v[1] = r.in_y;
      v[2] = r.in_z;
      // mode high means direction vector: no translation, no divide
      for (int k = 0; k < 3; k++) num[k] = row_sum(k, v, !r.mode);
      o.w_zero = 1'b0;
      if (r.mode) begin
         for (int k = 0; k < 3; k++) res[k] = clamp(num[k], clip);
      end else begin
         w = row_sum(3, v, 1'b1);
         if (w == 65536) begin
            for (int k = 0; k < 3; k++) res[k] = clamp(num[k], clip);
         end else if (w == 0) begin
            o.w_zero = 1'b1;
            clip = 1'b1;
            for (int k = 0; k < 3; k++)
               res[k] = (num[k] < 0) ? 32'h80000000 : 32'h7fffffff;
         end else begin
            for (int k = 0; k < 3; k++) res[k] = quotient(num[k], w, clip);
         end
      end
      o.out_x   = res[0];
      o.out_y   = res[1];
      o.out_z   = res[2];
      o.clipped = clip;
      return o;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
      errors++;
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) shadow_mtx[i] <= MTX_RESET[i];
         expected_rsp.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            shadow_mtx[csr_paddr[5:3]] <= csr_pwdata;
         if (req_valid && req_ready)
            expected_rsp.push_back(transform(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("[%0t] response with no request outstanding", $realtime);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.out_x !== want.out_x) report("out_x", rsp_data.out_x, want.out_x);
               if (rsp_data.out_y !== want.out_y) report("out_y", rsp_data.out_y, want.out_y);
               if (rsp_data.out_z !== want.out_z) report("out_z", rsp_data.out_z, want.out_z);
               if (rsp_data.w_zero !== want.w_zero)
                  report("w_zero", rsp_data.w_zero, want.w_zero);
               if (rsp_data.clipped !== want.clipped)
                  report("clipped", rsp_data.clipped, want.clipped);
            end
         end
      end
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives points and direction vectors through the 4x4 transform under a
// series of matrices written over APB, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
   import hpvt_pkg::*;

   localparam logic MODE_POINT  = 1'b0;
   localparam logic MODE_VECTOR = 1'b1;
   localparam int   PHASE_REQS  = 125;
   localparam int   NUM_PHASES  = 8;

   // matrix setups, one per phase
   typedef enum int {
      MTX_IDENTITY, MTX_AFFINE, MTX_PROJECTIVE, MTX_ALL_MAX,
      MTX_ALL_MIN, MTX_W_ZERO, MTX_RANDOM, MTX_ALL_ONES
   } mtx_kind_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [63:0]       csr_pwdata = '0;
   logic [63:0]       csr_prdata;
   logic              csr_pready;
   int                errors;
   int                pending;
   int                send_idle_pct = 0;   // sender gap odds, percent
   int                recv_stall_pct = 0;  // receiver stall odds, percent
   int                sent = 0;

   always #1 clock = ~clock;

   homogeneous_point_vector_transform u_dut (.*);

   hpvt_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr,
      .csr_pwdata, .errors, .pending
   );

   // response back-pressure, redrawn every cycle
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // setup cycle then access cycle; the register lands on the access edge
   task automatic csr_write(input int idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(idx * 8);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // mostly modest Q16.16 gains, sometimes any 32-bit pattern
   function automatic logic [31:0] rand_coef();
      if ($urandom_range(3) == 0) return $urandom;
      return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(3))
               0: return 32'h7fffffff;
               1: return 32'h80000000;
               2: return 32'h0;
               default: return 32'hffffffff;
            endcase
         end
         default: return 32'($signed($urandom_range(1 << 23)) - (1 << 22));
      endcase
   endfunction

   task automatic load_matrix(input mtx_kind_type kind);
      logic [31:0] c [16];
      for (int i = 0; i < 16; i++) c[i] = rand_coef();
      case (kind)
         MTX_IDENTITY:
            for (int i = 0; i < 16; i++) c[i] = (i % 5 == 0) ? 32'h10000 : 32'h0;
         MTX_AFFINE: begin
            // bottom row 0 0 0 1: w stays exactly one
            c[12] = 0; c[13] = 0; c[14] = 0; c[15] = 32'h10000;
         end
         MTX_PROJECTIVE: begin
            // small perspective terms keep w near one but rarely equal
            for (int i = 12; i < 15; i++) c[i] = 32'($signed($urandom_range(2048)) - 1024);
            c[15] = 32'h10000 + $urandom_range(4096);
         end
         MTX_ALL_MAX: for (int i = 0; i < 16; i++) c[i] = 32'h7fffffff;
         MTX_ALL_MIN: for (int i = 0; i < 16; i++) c[i] = 32'h80000000;
         MTX_W_ZERO: begin
            c[12] = 0; c[13] = 0; c[14] = 0; c[15] = 0;
         end
         MTX_ALL_ONES: for (int i = 0; i < 16; i++) c[i] = 32'hffffffff;
         default: ;
      endcase
      for (int i = 0; i < NUM_REGS; i++) csr_write(i, {c[2 * i], c[2 * i + 1]});
   endtask

   task automatic send_req(input logic mode, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data.mode <= mode;
      req_data.in_x <= x;
      req_data.in_y <= y;
      req_data.in_z <= z;
      // ready is settled at the falling edge, ahead of the accepting edge
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests under the reset identity: w is exactly one
      send_req(MODE_POINT, 32'h7fffffff, 32'h80000000, 32'h0);
      send_req(MODE_VECTOR, 32'h80000000, 32'h7fffffff, 32'hffffffff);
      send_req(MODE_POINT, 32'h00010000, 32'hffff0000, 32'h00000001);
      send_req(MODE_VECTOR, 32'h0, 32'h0, 32'h0);
      drain();

      // weight zero: saturated outputs by numerator sign
      load_matrix(MTX_W_ZERO);
      send_req(MODE_POINT, 32'h0, 32'h0, 32'h0);
      send_req(MODE_POINT, 32'h80000000, 32'h7fffffff, 32'h00018000);
      send_req(MODE_VECTOR, 32'h7fffffff, 32'h80000000, 32'hfffe8000);
      drain();

      // true divide and extreme coefficients
      load_matrix(MTX_PROJECTIVE);
      send_req(MODE_POINT, 32'h00030000, 32'hfffd0000, 32'h00008000);
      send_req(MODE_POINT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_req(MODE_VECTOR, 32'h00030000, 32'hfffd0000, 32'h00008000);
      drain();
      load_matrix(MTX_ALL_MAX);
      send_req(MODE_POINT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_req(MODE_VECTOR, 32'h80000000, 32'h80000000, 32'h80000000);
      send_req(MODE_POINT, 32'h00000001, 32'hffffffff, 32'h0);
      drain();
      load_matrix(MTX_ALL_MIN);
      send_req(MODE_POINT, 32'h80000000, 32'h7fffffff, 32'h80000000);
      send_req(MODE_VECTOR, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      drain();

      // random phases; idling rotates through four patterns and each phase ends fully drained
      for (int p = 0; p < NUM_PHASES; p++) begin
         load_matrix(mtx_kind_type'(p));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         for (int n = 0; n < PHASE_REQS; n++)
            send_req(logic'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord());
         drain();
      end

      recv_stall_pct = 0;
      repeat (50) @(posedge clock);
      $display("tb: %0d requests over %0d matrix setups, point and vector modes,",
               sent, NUM_PHASES + 5);
      $display("tb: with sender gaps and response stalls in turn");
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/hpvt_pkg.sv
hw/rtl/hpvt_csr.sv
hw/rtl/hpvt_dot_lane.sv
hw/rtl/hpvt_div_lane.sv
hw/rtl/homogeneous_point_vector_transform.sv
bench/hpvt_checker.sv
bench/tb.sv
